[rtl/core/fmps_pkg.sv]
// Package for the four-motor pattern PWM sequencer: codes, widths, segment ROM
// contents and the segment lookup helpers.
// No dependencies.
`timescale 1ns / 1ps

package fmps_pkg;

    // Sizing
    localparam int NUM_MOTORS     = 4;
    localparam int NUM_SETS       = 2;
    localparam int MAX_SEGMENTS   = 16;
    localparam int TICKS_PER_UNIT = 10;
    localparam int ENTRY_W        = 8;
    localparam int SEG_IDX_W      = $clog2(MAX_SEGMENTS);
    localparam int REMAIN_W       = $clog2(((1 << ENTRY_W) - 1) * TICKS_PER_UNIT + 1);

    typedef logic [SEG_IDX_W-1:0] t_seg_idx;
    typedef logic [SEG_IDX_W:0]   t_seg_cnt;
    typedef logic [REMAIN_W-1:0]  t_remain;
    typedef logic [ENTRY_W-1:0]   t_entry;
    typedef logic [1:0]           t_mode;
    typedef logic [2:0]           t_button;
    typedef logic [1:0]           t_cfg_idx;

    // Run modes
    localparam t_mode MODE_STOP = 2'd0;
    localparam t_mode MODE_AUTO = 2'd1;
    localparam t_mode MODE_STEP = 2'd2;
    localparam t_mode MODE_FULL = 2'd3;

    // Button scan codes
    localparam t_button BTN_STOP = 3'd0;
    localparam t_button BTN_AUTO = 3'd1;
    localparam t_button BTN_STEP = 3'd2;
    localparam t_button BTN_FULL = 3'd3;
    localparam t_button BTN_NONE = 3'd4;

    // Item kinds on the input tuser bit
    localparam logic ACT_TICK = 1'b0;

    // Configuration register indexes
    localparam t_cfg_idx CFG_PWM_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_DUTY_A     = 2'd1;
    localparam t_cfg_idx CFG_DUTY_B     = 2'd2;

    // Segment durations in units, [set][motor][segment]; unused slots are zero
    localparam t_entry SEG_TABLE [NUM_SETS][NUM_MOTORS][MAX_SEGMENTS] = '{
        '{
            '{8'd19, 8'd3,  8'd7,  8'd22, 8'd15, 8'd24, 8'd7,  8'd30,
              8'd8,  8'd12, 8'd7,  8'd12, 8'd7,  8'd37, 8'd0,  8'd0},
            '{8'd7,  8'd13, 8'd14, 8'd23, 8'd14, 8'd80, 8'd7,  8'd12,
              8'd7,  8'd12, 8'd7,  8'd12, 8'd0,  8'd0,  8'd0,  8'd0},
            '{8'd19, 8'd3,  8'd8,  8'd22, 8'd14, 8'd24, 8'd7,  8'd12,
              8'd7,  8'd12, 8'd7,  8'd12, 8'd7,  8'd56, 8'd0,  8'd0},
            '{8'd7,  8'd3,  8'd8,  8'd22, 8'd14, 8'd23, 8'd8,  8'd11,
              8'd8,  8'd67, 8'd8,  8'd30, 8'd0,  8'd0,  8'd0,  8'd0}
        },
        '{
            '{8'd0,  8'd0,  8'd12, 8'd19, 8'd12, 8'd19, 8'd12, 8'd19,
              8'd12, 8'd130, 8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
            '{8'd0,  8'd93, 8'd12, 8'd19, 8'd12, 8'd19, 8'd12, 8'd19,
              8'd12, 8'd37, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
            '{8'd0,  8'd13, 8'd12, 8'd19, 8'd12, 8'd130, 8'd12, 8'd19,
              8'd12, 8'd6,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
            '{8'd0,  8'd44, 8'd12, 8'd19, 8'd12, 8'd19, 8'd12, 8'd19,
              8'd12, 8'd86, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0}
        }
    };

    // Segments in use per [set][motor]
    localparam t_seg_cnt SEG_COUNT [NUM_SETS][NUM_MOTORS] = '{
        '{t_seg_cnt'(14), t_seg_cnt'(12), t_seg_cnt'(14), t_seg_cnt'(12)},
        '{t_seg_cnt'(10), t_seg_cnt'(10), t_seg_cnt'(10), t_seg_cnt'(10)}
    };

    // Active-low LED nibble per mode
    localparam logic [3:0] LED_TABLE [4] = '{4'hE, 4'hB, 4'h7, 4'hD};

    // Tick count loaded when a segment starts
    function automatic t_remain seg_reload(input logic set, input logic [1:0] motor,
                                           input t_seg_idx idx);
        return t_remain'(SEG_TABLE[set][motor][idx]) * t_remain'(TICKS_PER_UNIT);
    endfunction

    // Next segment index, wrapping at the end of the motor's table
    function automatic t_seg_idx seg_next(input logic set, input logic [1:0] motor,
                                          input t_seg_idx idx);
        t_seg_cnt nxt;
        nxt = {1'b0, idx} + t_seg_cnt'(1);
        if (nxt >= SEG_COUNT[set][motor]) begin
            return '0;
        end
        return nxt[SEG_IDX_W-1:0];
    endfunction

endpackage

[rtl/core/four_motor_pattern_pwm_sequencer.sv]
// Top level of the four-motor pattern PWM sequencer.
// Each result is registered on m_axis, or in the skid entry while the output stalls.
// One item per cycle when s_axis_tready is high; state update: one registered pass.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Reset (i_rst_n low, synchronous) stops all motors, selects set A and
// loads default PWM period 16, duty A 10, duty B 11.
`timescale 1ns / 1ps

module four_motor_pattern_pwm_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] button, [7:3] zero
    input  logic        s_axis_tuser,   // [0] action (0 tick, 1 scan)
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] motor_drive, [5:4] run_mode,
                                        // [6] pattern_set, [10:7] led_mask, [15:11] zero
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    import fmps_pkg::*;

    localparam int OUT_W = 11;

    // Configuration registers
    logic [7:0] r_pwm_period, r_duty_a, r_duty_b;

    // Sequencer state
    t_mode                 r_mode, n_mode;
    logic                  r_set, n_set;
    t_button               r_prev_button, n_prev_button;
    logic [7:0]            r_pwm_count, n_pwm_count;
    t_seg_idx              r_seg_idx    [NUM_MOTORS];
    t_seg_idx              n_seg_idx    [NUM_MOTORS];
    t_remain               r_seg_remain [NUM_MOTORS];
    t_remain               n_seg_remain [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] r_seg_on, n_seg_on;
    logic [NUM_MOTORS-1:0] r_drive, n_drive;

    // Output buffer
    logic             r_out_valid, r_skid_valid;
    logic [OUT_W-1:0] r_out_data, r_skid_data;
    logic [OUT_W-1:0] w_result;

    logic    w_accept_in;
    t_button w_button;
    logic    w_is_tick;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept_in   = s_axis_tvalid && s_axis_tready;
    assign w_button      = s_axis_tdata[2:0];
    assign w_is_tick     = (s_axis_tuser == ACT_TICK);

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= 8'd16;
            r_duty_a     <= 8'd10;
            r_duty_b     <= 8'd11;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PWM_PERIOD: r_pwm_period <= i_cfg_data;
                CFG_DUTY_A:     r_duty_a     <= i_cfg_data;
                CFG_DUTY_B:     r_duty_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state for one accepted item
    always_comb begin
        logic [7:0] v_duty;
        logic [7:0] v_pwm_inc;
        logic       v_set;
        t_seg_idx   v_idx;

        n_mode        = r_mode;
        n_set         = r_set;
        n_prev_button = r_prev_button;
        n_pwm_count   = r_pwm_count;
        n_seg_on      = r_seg_on;
        n_drive       = r_drive;
        n_seg_idx     = r_seg_idx;
        n_seg_remain  = r_seg_remain;
        v_duty        = r_set ? r_duty_b : r_duty_a;
        v_pwm_inc     = r_pwm_count + 8'd1;
        v_set         = (r_mode == MODE_FULL) ? !r_set : 1'b0;
        v_idx         = '0;

        if (w_accept_in) begin
            if (w_is_tick) begin
                // Full-mode tick: step every motor, gate with PWM
                if (r_mode == MODE_FULL) begin
                    for (int m = 0; m < NUM_MOTORS; m++) begin
                        if (r_seg_remain[m] != '0) begin
                            n_seg_remain[m] = r_seg_remain[m] - t_remain'(1);
                        end else begin
                            v_idx           = seg_next(r_set, 2'(m), r_seg_idx[m]);
                            n_seg_idx[m]    = v_idx;
                            n_seg_remain[m] = seg_reload(r_set, 2'(m), v_idx);
                            n_seg_on[m]     = !v_idx[0];
                        end
                        n_drive[NUM_MOTORS-1-m] = n_seg_on[m] && (r_pwm_count < v_duty);
                    end
                    n_pwm_count = (v_pwm_inc >= r_pwm_period) ? 8'd0 : v_pwm_inc;
                end
            end else begin
                // Button scan: act on a new press only
                if (w_button != BTN_NONE && w_button != r_prev_button) begin
                    n_drive = '0;
                    if (w_button == BTN_FULL) begin
                        n_mode = MODE_FULL;
                        n_set  = v_set;
                        for (int m = 0; m < NUM_MOTORS; m++) begin
                            n_seg_idx[m]    = '0;
                            n_seg_remain[m] = seg_reload(v_set, 2'(m), '0);
                            n_seg_on[m]     = 1'b1;
                        end
                    end else begin
                        n_set  = 1'b0;
                        n_mode = (w_button == BTN_AUTO || w_button == BTN_STEP)
                                 ? w_button[1:0] : MODE_STOP;
                    end
                end
                n_prev_button = w_button;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STOP;
            r_set         <= 1'b0;
            r_prev_button <= BTN_NONE;
            r_pwm_count   <= '0;
            r_seg_on      <= '0;
            r_drive       <= '0;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_seg_idx[m]    <= '0;
                r_seg_remain[m] <= '0;
            end
        end else begin
            r_mode        <= n_mode;
            r_set         <= n_set;
            r_prev_button <= n_prev_button;
            r_pwm_count   <= n_pwm_count;
            r_seg_on      <= n_seg_on;
            r_drive       <= n_drive;
            r_seg_idx     <= n_seg_idx;
            r_seg_remain  <= n_seg_remain;
        end
    end

    // Result word from the post-item state
    assign w_result = {LED_TABLE[n_mode], n_set, n_mode, n_drive};

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept_in;
            end
        end else if (w_accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_result;
        end else if (w_accept_in) begin
            r_skid_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - OUT_W){1'b0}}, r_out_data};

    // Segment bookkeeping consistency while running patterns
    logic w_seg_ok;
    always_comb begin
        w_seg_ok = 1'b1;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            if (r_seg_on[m] != !r_seg_idx[m][0]) w_seg_ok = 1'b0;
            if ({1'b0, r_seg_idx[m]} >= SEG_COUNT[r_set][m]) w_seg_ok = 1'b0;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while output register is empty");

    a_drive_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive != '0) |-> (r_mode == MODE_FULL))
        else $error("motor drive active outside full mode");

    a_set_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_set |-> (r_mode == MODE_FULL))
        else $error("pattern set B selected outside full mode");

    a_seg_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FULL) |-> w_seg_ok)
        else $error("segment index or on flag inconsistent in full mode");

    a_tick_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept_in && w_is_tick && r_mode != MODE_FULL) |=> $stable(r_pwm_count))
        else $error("PWM counter moved on a tick outside full mode");

endmodule
